@@ design/s1ds_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// s1ds_pkg
// types and fixed constants shared by the row smoother and its divide unit
// ----------------------------------------------------------------------------
package s1ds_pkg;

    localparam int DATA_W     = 32;
    localparam int CNT_W      = 5;
    localparam logic [CNT_W-1:0] CNT_RESET = 5'd30;

    // mean of three: (a + b + c + 1 + 3 * 2^31) / 3 on a 34-bit unsigned word
    localparam int DIVIDEND_W = 34;
    localparam logic [DIVIDEND_W-1:0] MEAN_OFFSET = 34'h1_8000_0001;

    // radix-4 long division by three, six digits per cycle
    localparam int DIV_DIGITS = 6;
    localparam int DIV_CYCLES = 3;
    localparam int DIV_PAD_W  = 2 * DIV_DIGITS * DIV_CYCLES;
    localparam int DIV_CNT_W  = 2;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic                     last_in;
    } item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result;
        logic                     last_out;
    } res_t;

endpackage

`default_nettype wire

@@ design/s1ds_div3.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// s1ds_div3
// unsigned floor division by three, radix-4 digits, fixed cycle count
// ----------------------------------------------------------------------------
module s1ds_div3 (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [s1ds_pkg::DIVIDEND_W-1:0]     dividend,
    output logic                                     done,
    output logic [s1ds_pkg::DIVIDEND_W-1:0]          quotient
);

    localparam int PW = s1ds_pkg::DIV_PAD_W;

    logic [PW-1:0]                       val_reg;
    logic [PW-1:0]                       quo_reg;
    logic [1:0]                          rem_reg;
    logic [s1ds_pkg::DIV_CNT_W-1:0]      cnt_reg;
    logic                                run_reg;
    logic                                done_reg;

    logic [PW-1:0]                       val_next;
    logic [PW-1:0]                       quo_next;
    logic [1:0]                          rem_next;

    always_comb
    begin
        logic [3:0] t;
        logic [1:0] qd;
        val_next = val_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        t        = '0;
        qd       = '0;
        for (int i = 0; i < s1ds_pkg::DIV_DIGITS; i++)
        begin
            t = {rem_next, val_next[PW-1 -: 2]};
            if (t >= 4'd9)
            begin
                qd       = 2'd3;
                rem_next = 2'(t - 4'd9);
            end
            else if (t >= 4'd6)
            begin
                qd       = 2'd2;
                rem_next = 2'(t - 4'd6);
            end
            else if (t >= 4'd3)
            begin
                qd       = 2'd1;
                rem_next = 2'(t - 4'd3);
            end
            else
            begin
                qd       = 2'd0;
                rem_next = t[1:0];
            end
            quo_next = {quo_next[PW-3:0], qd};
            val_next = {val_next[PW-3:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == s1ds_pkg::DIV_CNT_W'(s1ds_pkg::DIV_CYCLES - 1));
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == s1ds_pkg::DIV_CNT_W'(s1ds_pkg::DIV_CYCLES - 1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg <= PW'(dividend);
            quo_reg <= '0;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            val_reg <= val_next;
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[s1ds_pkg::DIVIDEND_W-1:0];

endmodule

`default_nettype wire

@@ design/seidel_1d_smoother.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// seidel_1d_smoother
// in-place gauss-seidel smoothing of one row of q16.16 samples held in a ram
// ----------------------------------------------------------------------------
// loading takes one cycle per word; busy stays low until the word with last_in
// after that word, busy stays high for SWEEPS sweeps (four by default) of the n
// interior points and then the read-out; each point waits on the divide unit
// inside the sweep recurrence; results come one per cycle and cannot be stalled;
// the last one shows in the first idle cycle; reset empties the row and sets the
// interior count to 30
// ----------------------------------------------------------------------------
module seidel_1d_smoother #(
    parameter int POINTS = 30,
    parameter int SWEEPS = 4
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire s1ds_pkg::item_t                 item,
    output logic                                 res_strobe,
    output s1ds_pkg::res_t                       res,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [s1ds_pkg::CNT_W-1:0]      cfg_data
);

    localparam int DEPTH = POINTS + 2;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int POS_W = $clog2(DEPTH + 1);
    localparam int SW_W  = (SWEEPS > 1) ? $clog2(SWEEPS) : 1;
    localparam int DW    = s1ds_pkg::DATA_W;
    localparam int UW    = s1ds_pkg::DIVIDEND_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRE0 = 3'd1;
    localparam logic [2:0] S_PRE1 = 3'd2;
    localparam logic [2:0] S_PRE2 = 3'd3;
    localparam logic [2:0] S_PRE3 = 3'd4;
    localparam logic [2:0] S_SUM  = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [DW-1:0]               mem [DEPTH];
    logic [DW-1:0]               rd_data_reg;
    logic                        rd_valid_reg;
    logic [DEPTH-1:0]            valid_reg;

    logic [2:0]                  state_reg, state_next;
    logic [POS_W-1:0]            load_pos_reg, load_pos_next;
    logic [IDX_W-1:0]            inner_reg, inner_next;
    logic [IDX_W-1:0]            pos_reg, pos_next;
    logic [SW_W-1:0]             sweep_reg, sweep_next;
    logic [s1ds_pkg::CNT_W-1:0]  count_reg;
    logic                        strobe_reg, strobe_next;
    logic                        last_reg, last_next;

    logic [DW-1:0]               left_reg, cur_reg, right_reg;

    logic                        rd_en;
    logic [IDX_W-1:0]            rd_addr;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    logic [DW-1:0]               wr_data;
    logic                        clear_all;

    logic [IDX_W-1:0]            inner_clamped;
    logic [DW-1:0]               rd_value;
    logic                        accept;
    logic                        div_start;
    logic                        div_done;
    logic [UW-1:0]               div_quotient;
    logic [UW-1:0]               sum;
    logic [DW-1:0]               mean;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign rd_value  = rd_valid_reg ? rd_data_reg : '0;

    always_comb
    begin
        if (count_reg == '0)
        begin
            inner_clamped = IDX_W'(1);
        end
        else if (int'(count_reg) > POINTS)
        begin
            inner_clamped = IDX_W'(POINTS);
        end
        else
        begin
            inner_clamped = IDX_W'(count_reg);
        end
    end

    assign sum = {{(UW-DW){left_reg[DW-1]}}, left_reg}
               + {{(UW-DW){cur_reg[DW-1]}}, cur_reg}
               + {{(UW-DW){right_reg[DW-1]}}, right_reg}
               + s1ds_pkg::MEAN_OFFSET;

    // quotient is the mean biased by 2^31
    assign mean = div_quotient[DW-1:0] ^ {1'b1, {(DW-1){1'b0}}};

    s1ds_div3 u_div3 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next    = state_reg;
        load_pos_next = load_pos_reg;
        inner_next    = inner_reg;
        pos_next      = pos_reg;
        sweep_next    = sweep_reg;
        strobe_next   = 1'b0;
        last_next     = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;
        clear_all     = 1'b0;
        div_start     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (load_pos_reg < POS_W'(DEPTH))
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = load_pos_reg[IDX_W-1:0];
                        wr_data       = item.sample;
                        load_pos_next = load_pos_reg + 1'b1;
                    end
                    if (item.last_in)
                    begin
                        inner_next = inner_clamped;
                        sweep_next = '0;
                        state_next = S_PRE0;
                    end
                end
            end
            S_PRE0:
            begin
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(0);
                state_next = S_PRE1;
            end
            S_PRE1:
            begin
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(1);
                state_next = S_PRE2;
            end
            S_PRE2:
            begin
                rd_en      = 1'b1;
                rd_addr    = IDX_W'(2);
                state_next = S_PRE3;
            end
            S_PRE3:
            begin
                pos_next   = IDX_W'(1);
                state_next = S_SUM;
            end
            S_SUM:
            begin
                div_start = 1'b1;
                if (pos_reg < inner_reg)
                begin
                    rd_en   = 1'b1;
                    rd_addr = pos_reg + IDX_W'(2);
                end
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pos_reg;
                    wr_data = mean;
                    if (pos_reg == inner_reg)
                    begin
                        if (sweep_reg == SW_W'(SWEEPS - 1))
                        begin
                            pos_next   = '0;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            sweep_next = sweep_reg + 1'b1;
                            state_next = S_PRE0;
                        end
                    end
                    else
                    begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = S_SUM;
                    end
                end
            end
            S_EMIT:
            begin
                rd_en       = 1'b1;
                rd_addr     = pos_reg;
                strobe_next = 1'b1;
                pos_next    = pos_reg + 1'b1;
                if (pos_reg == inner_reg + IDX_W'(1))
                begin
                    last_next     = 1'b1;
                    clear_all     = 1'b1;
                    load_pos_next = '0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            load_pos_reg <= '0;
            inner_reg    <= '0;
            pos_reg      <= '0;
            sweep_reg    <= '0;
            strobe_reg   <= 1'b0;
            last_reg     <= 1'b0;
            count_reg    <= s1ds_pkg::CNT_RESET;
            valid_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            load_pos_reg <= load_pos_next;
            inner_reg    <= inner_next;
            pos_reg      <= pos_next;
            sweep_reg    <= sweep_next;
            strobe_reg   <= strobe_next;
            last_reg     <= last_next;
            if (cfg_valid && cfg_ready)
            begin
                count_reg <= cfg_data;
            end
            if (clear_all)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // row ram, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // left is the updated neighbor, cur and right come from the previous sweep
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_PRE1:
            begin
                left_reg <= rd_value;
            end
            S_PRE2:
            begin
                cur_reg <= rd_value;
            end
            S_PRE3:
            begin
                right_reg <= rd_value;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    left_reg  <= mean;
                    cur_reg   <= right_reg;
                    right_reg <= rd_value;
                end
            end
            default:
            begin
                left_reg <= left_reg;
            end
        endcase
    end

    assign res_strobe   = strobe_reg;
    assign res.result   = rd_value;
    assign res.last_out = last_reg;

endmodule

`default_nettype wire
